// ----- design/vcu_pkg.sv -----
// Shared constants, codes and types for the vector clock unit.
package vcu_pkg;

  localparam int MAX_PROCS_DEF  = 8;
  localparam int STAMP_BITS_DEF = 16;

  localparam int ACT_W      = 2;
  localparam int ID_W       = 3;
  localparam int FIELD_W    = 16;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = 4;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_LOCAL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RECV  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_LOCAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MERGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   own_id;
    logic [STEP_W-1:0] step_amount;
    logic [CNT_W-1:0]  process_count;
  } cfg_t;

endpackage

// ----- design/vcu_clock_mem.sv -----
// Clock entry memory: one write port, one registered read port, write-first forwarding.
module vcu_clock_mem #(
  parameter int MAX_PROCS  = vcu_pkg::MAX_PROCS_DEF,
  parameter int STAMP_BITS = vcu_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_PROCS)-1:0] rd_addr,
  output logic [STAMP_BITS-1:0]        rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_PROCS)-1:0] wr_addr,
  input  logic [STAMP_BITS-1:0]        wr_data
);

  logic [STAMP_BITS-1:0] mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]  vld;
  logic [STAMP_BITS-1:0] mem_q;
  logic [STAMP_BITS-1:0] fwd_q;
  logic                  hit_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  // Entries not written since reset or clear read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      hit_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (clr) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= wr_en && (wr_addr == rd_addr);
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = hit_q ? fwd_q : (vld_q ? mem_q : '0);

endmodule

// ----- design/vcu_engine.sv -----
// Sequencer: read-modify-write of clock entries and the result register.
module vcu_engine #(
  parameter int MAX_PROCS  = vcu_pkg::MAX_PROCS_DEF,
  parameter int STAMP_BITS = vcu_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vcu_pkg::cfg_t                   cfg,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [vcu_pkg::ACT_W-1:0]       action,
  input  logic [vcu_pkg::ID_W-1:0]        entry_index,
  input  logic [vcu_pkg::FIELD_W-1:0]     stamp_value,
  input  logic                            is_final,
  input  logic [vcu_pkg::ID_W-1:0]        sender_id,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [vcu_pkg::ID_W-1:0]        out_index,
  output logic [vcu_pkg::FIELD_W-1:0]     out_value,
  output logic                            out_last,
  output logic [vcu_pkg::KIND_W-1:0]      out_kind,
  output logic [vcu_pkg::ID_W-1:0]        out_source,
  output logic                            mem_clr,
  output logic                            mem_rd_en,
  output logic [$clog2(MAX_PROCS)-1:0]    mem_rd_addr,
  input  logic [STAMP_BITS-1:0]           mem_rd_data,
  output logic                            mem_wr_en,
  output logic [$clog2(MAX_PROCS)-1:0]    mem_wr_addr,
  output logic [STAMP_BITS-1:0]           mem_wr_data
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = vcu_pkg::CNT_W;
  localparam logic [STAMP_BITS-1:0] SMAX = '1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUMP  = 2'd1;
  localparam logic [1:0] ST_SEND  = 2'd2;
  localparam logic [1:0] ST_MERGE = 2'd3;

  function automatic logic [STAMP_BITS-1:0] sat_add(input logic [STAMP_BITS-1:0] a,
                                                    input logic [vcu_pkg::STEP_W-1:0] b);
    logic [STAMP_BITS:0] s;
    s = {1'b0, a} + (STAMP_BITS+1)'(b);
    return s[STAMP_BITS] ? SMAX : s[STAMP_BITS-1:0];
  endfunction

  logic [1:0]                     state, state_next;
  logic [CW-1:0]                  cnt, cnt_next;
  logic [vcu_pkg::ACT_W-1:0]      act_q;
  logic [vcu_pkg::ID_W-1:0]       idx_q;
  logic [vcu_pkg::FIELD_W-1:0]    stamp_q;
  logic                           fin_q;
  logic [vcu_pkg::ID_W-1:0]       sender_q;

  logic [CW-1:0]                  n_use;
  logic                           own_ok, idx_ok, in_ok;
  logic                           accept, out_free, emit, last_elem;
  logic [vcu_pkg::ID_W-1:0]       e_index;
  logic [STAMP_BITS-1:0]          e_value;
  logic                           e_last;
  logic [vcu_pkg::KIND_W-1:0]     e_kind;
  logic [vcu_pkg::ID_W-1:0]       e_source;
  logic [STAMP_BITS-1:0]          sum_val, stamp_sat, merged;
  logic [31:0]                    stamp_w;

  // Clamp the entry count to [2, MAX_PROCS].
  always_comb begin
    n_use = cfg.process_count;
    if (cfg.process_count < CW'(2)) begin
      n_use = CW'(2);
    end else if (int'(cfg.process_count) > MAX_PROCS) begin
      n_use = CW'(MAX_PROCS);
    end
  end

  assign own_ok    = {1'b0, cfg.own_id} < n_use;
  assign idx_ok    = {1'b0, idx_q} < n_use;
  assign in_ok     = {1'b0, entry_index} < n_use;
  assign item_stall = (state != ST_IDLE);
  assign accept    = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign last_elem = (CW'(cnt + 1'b1) == n_use);

  assign stamp_w   = 32'(stamp_q);
  assign stamp_sat = (stamp_w > 32'(SMAX)) ? SMAX : STAMP_BITS'(stamp_w);
  assign merged    = (stamp_sat > mem_rd_data) ? stamp_sat : mem_rd_data;
  assign sum_val   = own_ok ? sat_add(mem_rd_data, cfg.step_amount) : '0;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    mem_clr     = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    emit        = 1'b0;
    e_index     = '0;
    e_value     = '0;
    e_last      = 1'b0;
    e_kind      = vcu_pkg::KIND_LOCAL;
    e_source    = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            vcu_pkg::ACT_LOCAL, vcu_pkg::ACT_SEND: begin
              mem_rd_en   = own_ok;
              mem_rd_addr = AW'(cfg.own_id);
              state_next  = ST_BUMP;
            end
            vcu_pkg::ACT_RECV: begin
              if (entry_index == '0) begin
                mem_rd_en   = own_ok;
                mem_rd_addr = AW'(cfg.own_id);
                state_next  = ST_BUMP;
              end else begin
                mem_rd_en   = in_ok;
                mem_rd_addr = AW'(entry_index);
                state_next  = ST_MERGE;
              end
            end
            default: begin
              mem_clr = 1'b1;
            end
          endcase
        end
      end
      ST_BUMP: begin
        mem_wr_addr = AW'(cfg.own_id);
        mem_wr_data = sum_val;
        unique case (act_q)
          vcu_pkg::ACT_LOCAL: begin
            if (out_free) begin
              mem_wr_en  = own_ok;
              emit       = 1'b1;
              e_index    = cfg.own_id;
              e_value    = sum_val;
              e_last     = 1'b1;
              e_kind     = vcu_pkg::KIND_LOCAL;
              state_next = ST_IDLE;
            end
          end
          vcu_pkg::ACT_SEND: begin
            mem_wr_en   = own_ok;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            cnt_next    = '0;
            state_next  = ST_SEND;
          end
          default: begin
            mem_wr_en   = own_ok;
            mem_rd_en   = idx_ok;
            mem_rd_addr = AW'(idx_q);
            state_next  = ST_MERGE;
          end
        endcase
      end
      ST_SEND: begin
        if (out_free) begin
          emit     = 1'b1;
          e_index  = cnt[vcu_pkg::ID_W-1:0];
          e_value  = mem_rd_data;
          e_last   = last_elem;
          e_kind   = vcu_pkg::KIND_SEND;
          e_source = last_elem ? cfg.own_id : '0;
          if (last_elem) begin
            state_next = ST_IDLE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(CW'(cnt + 1'b1));
            cnt_next    = CW'(cnt + 1'b1);
          end
        end
      end
      default: begin
        if (out_free) begin
          mem_wr_en   = idx_ok;
          mem_wr_addr = AW'(idx_q);
          mem_wr_data = merged;
          emit        = 1'b1;
          e_index     = idx_q;
          e_value     = idx_ok ? merged : '0;
          e_last      = 1'b1;
          e_kind      = vcu_pkg::KIND_MERGE;
          e_source    = fin_q ? sender_q : '0;
          state_next  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= action;
      idx_q    <= entry_index;
      stamp_q  <= stamp_value;
      fin_q    <= is_final;
      sender_q <= sender_id;
    end
    if (emit) begin
      out_index  <= e_index;
      out_value  <= vcu_pkg::FIELD_W'(e_value);
      out_last   <= e_last;
      out_kind   <= e_kind;
      out_source <= e_source;
    end
  end

endmodule

// ----- design/vector_clock_unit_top.sv -----
// Top level of the vector clock unit: configuration registers and block wiring.
//
// Usage notes:
// - Item channel (item_valid / item_stall): one action per transfer. Fields
//   action, entry_index, stamp_value, is_final, sender_id.
// - Result channel (result_valid / result_stall): one entry report per
//   transfer, held in an output register until taken.
// - Config channel (cfg_valid / cfg_ready): cfg_index 0 own_id, 1 step_amount,
//   2 process_count; cfg_ready is always high. Write only while idle.
// - Timing: the memory read is issued at the accepting edge; the result is
//   registered from the state that emits it: BUMP for a local item, MERGE for
//   a receive (BUMP first if entry_index is 0); a send goes BUMP, then SEND,
//   each entry in use, one per cycle unless stalled. A clear stays in IDLE.
// - The block takes one item at a time; the single read port of the entry
//   memory and the read-modify-write on it set the rate.
// - A stalled result holds the engine in the state that emits, with its read
//   data held, until the result register frees up.
// - Reset: all entries read as zero (per-entry valid bits are cleared),
//   own_id 0, step_amount 1, process_count 8. Clear also takes effect
//   through the valid bits.
module vector_clock_unit_top #(
  parameter int MAX_PROCS  = vcu_pkg::MAX_PROCS_DEF,
  parameter int STAMP_BITS = vcu_pkg::STAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [vcu_pkg::ACT_W-1:0]        action,
  input  logic [vcu_pkg::ID_W-1:0]         entry_index,
  input  logic [vcu_pkg::FIELD_W-1:0]      stamp_value,
  input  logic                             is_final,
  input  logic [vcu_pkg::ID_W-1:0]         sender_id,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [vcu_pkg::ID_W-1:0]         out_index,
  output logic [vcu_pkg::FIELD_W-1:0]      out_value,
  output logic                             out_last,
  output logic [vcu_pkg::KIND_W-1:0]       out_kind,
  output logic [vcu_pkg::ID_W-1:0]         out_source,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vcu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vcu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_PROCS);

  vcu_pkg::cfg_t           cfg;
  logic                    mem_clr;
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  logic [STAMP_BITS-1:0]   mem_rd_data;
  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic [STAMP_BITS-1:0]   mem_wr_data;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id        <= '0;
      cfg.step_amount   <= vcu_pkg::STEP_W'(1);
      cfg.process_count <= vcu_pkg::CNT_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcu_pkg::REG_OWN_ID: cfg.own_id      <= cfg_data[vcu_pkg::ID_W-1:0];
        vcu_pkg::REG_STEP:   cfg.step_amount <= cfg_data[vcu_pkg::STEP_W-1:0];
        vcu_pkg::REG_PCOUNT: cfg.process_count <= cfg_data[vcu_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  vcu_clock_mem #(
    .MAX_PROCS  (MAX_PROCS),
    .STAMP_BITS (STAMP_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (mem_clr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  vcu_engine #(
    .MAX_PROCS  (MAX_PROCS),
    .STAMP_BITS (STAMP_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .entry_index  (entry_index),
    .stamp_value  (stamp_value),
    .is_final     (is_final),
    .sender_id    (sender_id),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_index    (out_index),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_kind     (out_kind),
    .out_source   (out_source),
    .mem_clr      (mem_clr),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data)
  );

endmodule
